// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion pipeline
// Holds the fixed-point format, the pipeline dimensions, the branch codes
// and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   // Fixed-point format of inputs and outputs.
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 14;
   localparam int LIMIT     = 1 << FRAC_BITS;

   // Internal widths.
   localparam int EXT_W   = DATA_W + 3;          // sums of three elements
   localparam int RAD_W   = 18;                  // positive radicand
   localparam int X_W     = RAD_W + FRAC_BITS;   // radicand scaled for sqrt
   localparam int ROOT_W  = X_W / 2;
   localparam int SQR_W   = ROOT_W + 4;          // sqrt partial remainder
   localparam int MAG_W   = DATA_W + 1;          // numerator magnitude, up to 2^16
   localparam int DIV_W   = 32;                  // dividend and quotient
   localparam int DVSR_W  = ROOT_W + 1;          // divisor 2*s
   localparam int DREM_W  = DVSR_W + 1;          // division partial remainder

   // Pipeline dimensions: two root digits and two quotient bits per stage.
   localparam int SQ_STAGES  = ROOT_W / 2;
   localparam int DIV_STAGES = DIV_W / 2;
   localparam int LAST       = SQ_STAGES + DIV_STAGES + 1;

   // Branch codes: which component equals S/4.
   localparam logic [1:0] BR_W = 2'd0;
   localparam logic [1:0] BR_X = 2'd1;
   localparam logic [1:0] BR_Y = 2'd2;
   localparam logic [1:0] BR_Z = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_w;
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic                     bad_matrix;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: trace-based matrix to unit quaternion
// Fully pipelined: branch select, digit-pipelined square root, three
// parallel pipelined dividers and a saturating output register.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while the output is not stalled; the 8 root
// stages and 16 divider stages each retire two bits, and the whole pipe moves
// whenever the output moves.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   typedef struct packed {
      logic       bad;
      logic [1:0] big;
      logic [2:0] neg;
   } meta_type;

   // Pipeline advance: everything moves unless a result is held.
   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   logic     vld_ff   [0:LAST];
   logic     vld_in   [0:LAST];
   meta_type meta_ff  [0:LAST];
   meta_type meta_in  [0:LAST];

   logic [X_W-1:0]    sq_x_ff   [0:SQ_STAGES];
   logic [X_W-1:0]    sq_x_in   [0:SQ_STAGES];
   logic [SQR_W-1:0]  sq_rem_ff [0:SQ_STAGES];
   logic [SQR_W-1:0]  sq_rem_in [0:SQ_STAGES];
   logic [ROOT_W-1:0] sq_res_ff [0:SQ_STAGES];
   logic [ROOT_W-1:0] sq_res_in [0:SQ_STAGES];
   logic [MAG_W-1:0]  sq_mag_ff [0:SQ_STAGES][0:2];
   logic [MAG_W-1:0]  sq_mag_in [0:SQ_STAGES][0:2];

   logic [DVSR_W-1:0] dv_d_ff   [0:DIV_STAGES];
   logic [DVSR_W-1:0] dv_d_in   [0:DIV_STAGES];
   logic [ROOT_W-1:0] dv_big_ff [0:DIV_STAGES];
   logic [ROOT_W-1:0] dv_big_in [0:DIV_STAGES];
   logic [DIV_W-1:0]  dv_q_ff   [0:DIV_STAGES][0:2];
   logic [DIV_W-1:0]  dv_q_in   [0:DIV_STAGES][0:2];
   logic [DREM_W-1:0] dv_rem_ff [0:DIV_STAGES][0:2];
   logic [DREM_W-1:0] dv_rem_in [0:DIV_STAGES][0:2];

   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   // Front stage: trace, branch choice, radicand and numerators.
   always_comb begin
      logic signed [EXT_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
      logic signed [EXT_W-1:0] one, tr, r;
      logic signed [EXT_W-1:0] n [0:2];
      logic [EXT_W-1:0]        m;
      logic [1:0]              big;
      logic [X_W-1:0]          x;
      logic [SQR_W-1:0]        rem, trial;
      logic [ROOT_W-1:0]       res;
      a00 = {{3{req_payload.m00[DATA_W-1]}}, req_payload.m00};
      a01 = {{3{req_payload.m01[DATA_W-1]}}, req_payload.m01};
      a02 = {{3{req_payload.m02[DATA_W-1]}}, req_payload.m02};
      a10 = {{3{req_payload.m10[DATA_W-1]}}, req_payload.m10};
      a11 = {{3{req_payload.m11[DATA_W-1]}}, req_payload.m11};
      a12 = {{3{req_payload.m12[DATA_W-1]}}, req_payload.m12};
      a20 = {{3{req_payload.m20[DATA_W-1]}}, req_payload.m20};
      a21 = {{3{req_payload.m21[DATA_W-1]}}, req_payload.m21};
      a22 = {{3{req_payload.m22[DATA_W-1]}}, req_payload.m22};
      one = EXT_W'(LIMIT);
      tr  = a00 + a11 + a22;
      if (tr > 0) begin
         big  = BR_W;
         r    = tr + one;
         n[0] = a21 - a12;
         n[1] = a02 - a20;
         n[2] = a10 - a01;
      end else if (a00 > a11 && a00 > a22) begin
         big  = BR_X;
         r    = one + a00 - a11 - a22;
         n[0] = a21 - a12;
         n[1] = a01 + a10;
         n[2] = a02 + a20;
      end else if (a11 > a22) begin
         big  = BR_Y;
         r    = one + a11 - a00 - a22;
         n[0] = a02 - a20;
         n[1] = a01 + a10;
         n[2] = a12 + a21;
      end else begin
         big  = BR_Z;
         r    = one + a22 - a00 - a11;
         n[0] = a10 - a01;
         n[1] = a02 + a20;
         n[2] = a12 + a21;
      end
      vld_in[0]      = req_valid;
      meta_in[0].bad = (r <= 0);
      meta_in[0].big = big;
      for (int j = 0; j < 3; j++) begin
         meta_in[0].neg[j] = n[j][EXT_W-1];
         m = n[j][EXT_W-1] ? EXT_W'(-n[j]) : EXT_W'(n[j]);
         sq_mag_in[0][j] = m[MAG_W-1:0];
      end
      sq_x_in[0]   = (r <= 0) ? '0 : {r[RAD_W-1:0], {FRAC_BITS{1'b0}}};
      sq_rem_in[0] = '0;
      sq_res_in[0] = '0;

      // Valid and side-band bits follow the items down the pipe.
      for (int k = 1; k <= LAST; k++) begin
         vld_in[k]  = vld_ff[k-1];
         meta_in[k] = meta_ff[k-1];
      end

      // Square root stages: two result digits per stage.
      for (int k = 1; k <= SQ_STAGES; k++) begin
         x   = sq_x_ff[k-1];
         rem = sq_rem_ff[k-1];
         res = sq_res_ff[k-1];
         for (int t = 0; t < 2; t++) begin
            rem   = {rem[SQR_W-3:0], x[X_W-1:X_W-2]};
            trial = {{(SQR_W-ROOT_W-2){1'b0}}, res, 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               res = {res[ROOT_W-2:0], 1'b1};
            end else begin
               res = {res[ROOT_W-2:0], 1'b0};
            end
            x = {x[X_W-3:0], 2'b00};
         end
         sq_x_in[k]   = x;
         sq_rem_in[k] = rem;
         sq_res_in[k] = res;
         for (int j = 0; j < 3; j++) begin
            sq_mag_in[k][j] = sq_mag_ff[k-1][j];
         end
      end
   end

   // Divider setup: dividends n*2^F + s, divisor 2*s, and the S/4 term.
   always_comb begin
      logic [ROOT_W-1:0] s;
      logic [ROOT_W:0]   s1;
      logic [DIV_W-1:0]  q;
      logic [DREM_W-1:0] rem;
      logic              qb;
      s  = sq_res_ff[SQ_STAGES];
      s1 = {1'b0, s} + 1'b1;
      dv_d_in[0]   = {s, 1'b0};
      dv_big_in[0] = s1[ROOT_W:1];
      for (int j = 0; j < 3; j++) begin
         dv_q_in[0][j] = {{(DIV_W-MAG_W-FRAC_BITS){1'b0}},
                          sq_mag_ff[SQ_STAGES][j], {FRAC_BITS{1'b0}}}
                         + {{(DIV_W-ROOT_W){1'b0}}, s};
         dv_rem_in[0][j] = '0;
      end

      // Divider stages: two quotient bits per stage in each of three lanes.
      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_d_in[k]   = dv_d_ff[k-1];
         dv_big_in[k] = dv_big_ff[k-1];
         for (int j = 0; j < 3; j++) begin
            q   = dv_q_ff[k-1][j];
            rem = dv_rem_ff[k-1][j];
            for (int t = 0; t < 2; t++) begin
               rem = {rem[DREM_W-2:0], q[DIV_W-1]};
               qb  = (rem >= {1'b0, dv_d_ff[k-1]});
               if (qb) begin
                  rem = rem - {1'b0, dv_d_ff[k-1]};
               end
               q = {q[DIV_W-2:0], qb};
            end
            dv_q_in[k][j]   = q;
            dv_rem_in[k][j] = rem;
         end
      end
   end

   // Output stage: saturate, apply signs, place the components and zero a flagged result.
   always_comb begin
      logic [DATA_W-1:0] c [0:2];
      logic [DATA_W-1:0] b;
      logic [DIV_W-1:0]  q;
      meta_type          mt;
      mt = meta_ff[LAST];
      for (int j = 0; j < 3; j++) begin
         q    = dv_q_ff[DIV_STAGES][j];
         c[j] = (q > DIV_W'(LIMIT)) ? DATA_W'(LIMIT) : q[DATA_W-1:0];
         if (mt.neg[j]) begin
            c[j] = DATA_W'(-c[j]);
         end
      end
      b = (dv_big_ff[DIV_STAGES] > ROOT_W'(LIMIT)) ? DATA_W'(LIMIT)
                                                    : dv_big_ff[DIV_STAGES];
      case (mt.big)
         BR_W: begin
            rsp_payload_in.quat_w = b;    rsp_payload_in.quat_x = c[0];
            rsp_payload_in.quat_y = c[1]; rsp_payload_in.quat_z = c[2];
         end
         BR_X: begin
            rsp_payload_in.quat_w = c[0]; rsp_payload_in.quat_x = b;
            rsp_payload_in.quat_y = c[1]; rsp_payload_in.quat_z = c[2];
         end
         BR_Y: begin
            rsp_payload_in.quat_w = c[0]; rsp_payload_in.quat_x = c[1];
            rsp_payload_in.quat_y = b;    rsp_payload_in.quat_z = c[2];
         end
         default: begin
            rsp_payload_in.quat_w = c[0]; rsp_payload_in.quat_x = c[1];
            rsp_payload_in.quat_y = c[2]; rsp_payload_in.quat_z = b;
         end
      endcase
      rsp_payload_in.bad_matrix = mt.bad;
      if (mt.bad) begin
         rsp_payload_in.quat_w = '0;
         rsp_payload_in.quat_x = '0;
         rsp_payload_in.quat_y = '0;
         rsp_payload_in.quat_z = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= vld_in[k];
         end
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= LAST; k++) begin
            meta_ff[k] <= meta_in[k];
         end
         for (int k = 0; k <= SQ_STAGES; k++) begin
            sq_x_ff[k]   <= sq_x_in[k];
            sq_rem_ff[k] <= sq_rem_in[k];
            sq_res_ff[k] <= sq_res_in[k];
            for (int j = 0; j < 3; j++) begin
               sq_mag_ff[k][j] <= sq_mag_in[k][j];
            end
         end
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_d_ff[k]   <= dv_d_in[k];
            dv_big_ff[k] <= dv_big_in[k];
            for (int j = 0; j < 3; j++) begin
               dv_q_ff[k][j]   <= dv_q_in[k][j];
               dv_rem_ff[k][j] <= dv_rem_in[k][j];
            end
         end
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A flagged matrix gives an all-zero quaternion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_matrix |->
         rsp_payload.quat_w == 0 && rsp_payload.quat_x == 0 &&
         rsp_payload.quat_y == 0 && rsp_payload.quat_z == 0)
      else $error("bad matrix result is not zero");

   // Every component stays within the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_payload.quat_w <= LIMIT && rsp_payload.quat_w >= -LIMIT &&
         rsp_payload.quat_x <= LIMIT && rsp_payload.quat_x >= -LIMIT &&
         rsp_payload.quat_y <= LIMIT && rsp_payload.quat_y >= -LIMIT &&
         rsp_payload.quat_z <= LIMIT && rsp_payload.quat_z >= -LIMIT)
      else $error("quaternion component out of range");

   // An accepted item enters the first stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted item lost at pipeline entry");

endmodule

`default_nettype wire
